/* hw/rtl/kqks_pkg.sv */
// Shared types, codes and defaults for the keystroke queue key-state block.
package kqks_pkg;

	localparam int DEF_QUEUE_DEPTH = 16;
	localparam int DEF_KEY_WORDS   = 8;

	localparam int CODE_W     = 7;
	localparam int WORD_W     = 16;
	localparam int INSTR_W    = 32;
	localparam int WIDX_W     = 3;
	localparam int ENTRY_W    = CODE_W + 1;
	localparam int S_TDATA_W  = 48;
	localparam int APB_ADDR_W = 4;
	localparam int APB_DATA_W = 32;

	localparam logic [INSTR_W-1:0] THRESHOLD_RESET = 32'd2400;

	// item kinds carried on s_tuser
	typedef enum logic [1:0] {
		OP_KEY  = 2'd0,
		OP_TICK = 2'd1,
		OP_READ = 2'd2
	} op_t;

	localparam logic [1:0] QMODE_DIRECT = 2'd0;
	localparam logic       FMODE_ONE    = 1'b0;
	localparam logic       FMODE_RUN    = 1'b1;

	localparam logic [1:0] REG_QUEUE_MODE = 2'd0;
	localparam logic [1:0] REG_FLUSH_MODE = 2'd1;
	localparam logic [1:0] REG_INSTR_THR  = 2'd2;

	typedef struct packed {
		logic capture;
		logic direct;
		logic push;
		logic read_word;
		logic mark_flush;
		logic walk_start;
		logic walk_step;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic code_nz;
		logic count_zero;
		logic last_entry;
		logic flush_due;
		logic seen_hit;
	} sts_t;

endpackage

/* hw/rtl/kqks_dp.sv */
// Datapath: key-state words, event queue memory, pointers and flush bookkeeping.
module kqks_dp #(
	parameter int QUEUE_DEPTH = kqks_pkg::DEF_QUEUE_DEPTH,
	parameter int KEY_WORDS   = kqks_pkg::DEF_KEY_WORDS,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int PTR_W      = $clog2(QUEUE_DEPTH)
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  kqks_pkg::cmd_t                    cmd,
	output kqks_pkg::sts_t                    sts,
	input  logic [1:0]                        in_op,
	input  logic [kqks_pkg::CODE_W-1:0]       in_code,
	input  logic                              in_down,
	input  logic [kqks_pkg::INSTR_W-1:0]      in_now,
	input  logic [kqks_pkg::WIDX_W-1:0]       in_widx,
	input  logic [kqks_pkg::INSTR_W-1:0]      instr_threshold,
	output logic [kqks_pkg::WORD_W-1:0]       key_word,
	output logic                              dropped,
	output logic [CNT_W-1:0]                  queue_count
);

	localparam int SEEN_N = 2 ** kqks_pkg::CODE_W;

	kqks_pkg::op_t                    op_q;
	logic [kqks_pkg::CODE_W-1:0]      code_q;
	logic                             down_q;
	logic [kqks_pkg::INSTR_W-1:0]     now_q;
	logic [kqks_pkg::WIDX_W-1:0]      widx_q;

	logic [kqks_pkg::WORD_W-1:0]      key_state_q [KEY_WORDS];
	logic [kqks_pkg::WORD_W-1:0]      key_next [KEY_WORDS];
	logic [kqks_pkg::ENTRY_W-1:0]     queue_mem_q [QUEUE_DEPTH];
	logic [kqks_pkg::ENTRY_W-1:0]     rdata_q;
	logic [PTR_W-1:0]                 head_q;
	logic [PTR_W-1:0]                 tail_q;
	logic [CNT_W-1:0]                 count_q;
	logic [kqks_pkg::INSTR_W-1:0]     last_q;
	logic [SEEN_N-1:0]                seen_q;
	logic [kqks_pkg::INSTR_W:0]       elapsed_q;
	logic                             neq_q;
	logic [kqks_pkg::WORD_W-1:0]      word_q;
	logic                             dropped_q;

	logic                             full;
	logic                             mem_we;
	logic [PTR_W-1:0]                 tail_inc;
	logic [PTR_W-1:0]                 rd_addr;
	logic                             ap_en;
	logic [kqks_pkg::ENTRY_W-1:0]     ap_entry;
	logic [kqks_pkg::WORD_W-1:0]      ap_bit;
	logic [kqks_pkg::WORD_W-1:0]      rd_word;

	function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
		if (p == PTR_W'(QUEUE_DEPTH - 1))
			return '0;
		else
			return p + 1'b1;
	endfunction

	assign full     = (count_q == CNT_W'(QUEUE_DEPTH));
	assign mem_we   = cmd.push && !full;
	assign tail_inc = ptr_inc(tail_q);
	// the walk reads ahead: the head at start, the following slot on each step
	assign rd_addr  = cmd.walk_start ? head_q : ptr_inc(head_q);

	assign ap_en    = cmd.direct || cmd.walk_step;
	assign ap_entry = cmd.direct ? {down_q, code_q} : rdata_q;
	assign ap_bit   = 16'h8000 >> ap_entry[3:0];

	always_comb begin
		key_next = key_state_q;
		for (int k = 0; k < KEY_WORDS; k++) begin
			if ({2'b00, ap_entry[kqks_pkg::CODE_W-1:4]} == 5'(k)) begin
				if (ap_entry[kqks_pkg::ENTRY_W-1])
					key_next[k] = key_state_q[k] & ~ap_bit;
				else
					key_next[k] = key_state_q[k] | ap_bit;
			end
		end
	end

	// words beyond the stored set read as all keys up
	always_comb begin
		rd_word = '1;
		for (int k = 0; k < KEY_WORDS; k++) begin
			if ({2'b00, widx_q} == 5'(k))
				rd_word = key_state_q[k];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q   <= kqks_pkg::op_t'(in_op);
			code_q <= in_code;
			down_q <= in_down;
			now_q  <= in_now;
			widx_q <= in_widx;
		end
		if (now_q > last_q)
			elapsed_q <= {1'b0, now_q} - {1'b0, last_q};
		else
			elapsed_q <= {1'b0, now_q} + {1'b0, ~last_q};
		neq_q <= (now_q != last_q);
	end

	always_ff @(posedge clk) begin
		if (mem_we)
			queue_mem_q[tail_inc] <= {down_q, code_q};
		rdata_q <= queue_mem_q[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int k = 0; k < KEY_WORDS; k++)
				key_state_q[k] <= '1;
			head_q    <= '0;
			tail_q    <= PTR_W'(QUEUE_DEPTH - 1);
			count_q   <= '0;
			last_q    <= '0;
			seen_q    <= '0;
			word_q    <= '0;
			dropped_q <= 1'b0;
		end else begin
			if (cmd.capture) begin
				word_q    <= '0;
				dropped_q <= 1'b0;
			end
			if (cmd.read_word)
				word_q <= rd_word;
			if (cmd.push) begin
				if (full) begin
					dropped_q <= 1'b1;
				end else begin
					tail_q  <= tail_inc;
					count_q <= count_q + 1'b1;
				end
			end
			if (cmd.mark_flush)
				last_q <= now_q;
			if (ap_en)
				key_state_q <= key_next;
			if (cmd.walk_start)
				seen_q <= '0;
			if (cmd.walk_step) begin
				seen_q[rdata_q[kqks_pkg::CODE_W-1:0]] <= 1'b1;
				// head follows the walk, so a stop leaves it on the repeated entry
				if (count_q == CNT_W'(1)) begin
					head_q  <= '0;
					tail_q  <= PTR_W'(QUEUE_DEPTH - 1);
					count_q <= '0;
				end else begin
					head_q  <= ptr_inc(head_q);
					count_q <= count_q - 1'b1;
				end
			end
		end
	end

	assign sts.op         = op_q;
	assign sts.code_nz    = (code_q != '0);
	assign sts.count_zero = (count_q == '0);
	assign sts.last_entry = (count_q == CNT_W'(1));
	assign sts.flush_due  = (count_q != '0) && neq_q &&
		(elapsed_q > {1'b0, instr_threshold});
	assign sts.seen_hit   = seen_q[rdata_q[kqks_pkg::CODE_W-1:0]];

	assign key_word    = word_q;
	assign dropped     = dropped_q;
	assign queue_count = count_q;

	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("queue count beyond depth");

	a_empty_rewound: assert property (@(posedge clk) disable iff (!arst_n)
		(count_q == '0) |-> (head_q == '0) && (tail_q == PTR_W'(QUEUE_DEPTH - 1)))
		else $error("empty queue with pointers not rewound");

	a_full_drop: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.push && full) |=> (count_q == $past(count_q)) && dropped_q)
		else $error("push into full queue not dropped");

endmodule

/* hw/rtl/kqks_ctrl.sv */
// Controller: sequences decode, instruction-count check and queue walk per word.
module kqks_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           in_valid,
	output logic           in_ready,
	input  logic           out_free,
	output logic           load_out,
	input  logic [1:0]     queue_mode,
	input  logic           flush_mode,
	input  kqks_pkg::sts_t sts,
	output kqks_pkg::cmd_t cmd
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECODE,
		ST_INSTR,
		ST_WALK,
		ST_FINISH
	} state_t;

	state_t state_q;
	state_t state_nxt;
	logic   instr_mode;

	// modes two and three both flush on instruction count
	assign instr_mode = queue_mode[1];
	assign in_ready   = (state_q == ST_IDLE);

	always_comb begin
		cmd       = '0;
		load_out  = 1'b0;
		state_nxt = state_q;
		unique case (state_q)
			ST_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_nxt   = ST_DECODE;
				end
			end
			ST_DECODE: begin
				unique case (sts.op)
					kqks_pkg::OP_KEY: begin
						if (!sts.code_nz) begin
							state_nxt = ST_FINISH;
						end else if (queue_mode == kqks_pkg::QMODE_DIRECT) begin
							cmd.direct = 1'b1;
							state_nxt  = ST_FINISH;
						end else begin
							cmd.push  = 1'b1;
							state_nxt = instr_mode ? ST_INSTR : ST_FINISH;
						end
					end
					kqks_pkg::OP_TICK: begin
						if (instr_mode) begin
							state_nxt = ST_INSTR;
						end else if (sts.count_zero) begin
							state_nxt = ST_FINISH;
						end else begin
							cmd.walk_start = 1'b1;
							state_nxt      = ST_WALK;
						end
					end
					kqks_pkg::OP_READ: begin
						cmd.read_word = 1'b1;
						state_nxt     = ST_FINISH;
					end
					default: begin
						state_nxt = ST_FINISH;
					end
				endcase
			end
			ST_INSTR: begin
				if (sts.flush_due) begin
					cmd.mark_flush = 1'b1;
					cmd.walk_start = 1'b1;
					state_nxt      = ST_WALK;
				end else begin
					state_nxt = ST_FINISH;
				end
			end
			ST_WALK: begin
				// stop before a code already applied in this run
				if (flush_mode == kqks_pkg::FMODE_RUN && sts.seen_hit) begin
					state_nxt = ST_FINISH;
				end else begin
					cmd.walk_step = 1'b1;
					if (sts.last_entry || flush_mode == kqks_pkg::FMODE_ONE)
						state_nxt = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (out_free) begin
					load_out  = 1'b1;
					state_nxt = ST_IDLE;
				end
			end
			default: begin
				state_nxt = ST_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_nxt;
	end

endmodule

/* hw/rtl/keystroke_queue_key_state_core.sv */
// Top level: configuration registers, stream ports, output register, controller and datapath.
//
// Tracks an active-low key-state vector from key events, either applying them at once or
// through a ring queue that a flush tick or the instruction count drains. Each word on
// s_tdata/s_tuser gives one word on m_tdata. For reads, direct events and plain queued
// events the controller steps through decode and finish states, loads the result and then
// returns to idle to take the next word; an instruction-count check adds a check state;
// a flush adds a walk step per queue entry applied, read one per cycle from the queue
// memory, and one more where a run stops at a repeated code. A result waits in the
// output register while the next word is accepted; a further result waits until that
// register is taken. Configuration reads and writes go through the APB port.
module keystroke_queue_key_state_core #(
	parameter int QUEUE_DEPTH = kqks_pkg::DEF_QUEUE_DEPTH,
	parameter int KEY_WORDS   = kqks_pkg::DEF_KEY_WORDS,
	localparam int CNT_W      = $clog2(QUEUE_DEPTH + 1),
	localparam int OUT_BITS   = kqks_pkg::WORD_W + 1 + CNT_W,
	localparam int OUT_W      = ((OUT_BITS + 7) / 8) * 8
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              psel,
	input  logic                              penable,
	input  logic                              pwrite,
	input  logic [kqks_pkg::APB_ADDR_W-1:0]   paddr,
	input  logic [kqks_pkg::APB_DATA_W-1:0]   pwdata,
	output logic [kqks_pkg::APB_DATA_W-1:0]   prdata,
	output logic                              pready,
	input  logic                              s_tvalid,
	output logic                              s_tready,
	// key_code[6:0], key_down[7], instr_count[39:8], word_index[42:40]
	input  logic [kqks_pkg::S_TDATA_W-1:0]    s_tdata,
	// op[1:0]
	input  logic [1:0]                        s_tuser,
	output logic                              m_tvalid,
	input  logic                              m_tready,
	// key_word[15:0], dropped[16], queue_count[16+CNT_W:17]
	output logic [OUT_W-1:0]                  m_tdata
);

	logic [1:0]                   queue_mode_q;
	logic                         flush_mode_q;
	logic [kqks_pkg::INSTR_W-1:0] instr_thr_q;
	logic                         cfg_wr;

	logic                         out_valid_q;
	logic [OUT_BITS-1:0]          out_data_q;
	logic                         out_free;
	logic                         load_out;

	kqks_pkg::cmd_t               cmd;
	kqks_pkg::sts_t               sts;
	logic [kqks_pkg::WORD_W-1:0]  key_word;
	logic                         dropped;
	logic [CNT_W-1:0]             queue_count;

	assign pready = 1'b1;
	assign cfg_wr = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			queue_mode_q <= kqks_pkg::QMODE_DIRECT;
			flush_mode_q <= kqks_pkg::FMODE_ONE;
			instr_thr_q  <= kqks_pkg::THRESHOLD_RESET;
		end else if (cfg_wr) begin
			unique case (paddr[3:2])
				kqks_pkg::REG_QUEUE_MODE: queue_mode_q <= pwdata[1:0];
				kqks_pkg::REG_FLUSH_MODE: flush_mode_q <= pwdata[0];
				kqks_pkg::REG_INSTR_THR:  instr_thr_q  <= pwdata;
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			kqks_pkg::REG_QUEUE_MODE: prdata = {30'd0, queue_mode_q};
			kqks_pkg::REG_FLUSH_MODE: prdata = {31'd0, flush_mode_q};
			kqks_pkg::REG_INSTR_THR:  prdata = instr_thr_q;
			default:                  prdata = '0;
		endcase
	end

	assign out_free = !out_valid_q || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			out_valid_q <= 1'b0;
		else if (load_out)
			out_valid_q <= 1'b1;
		else if (m_tready)
			out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (load_out)
			out_data_q <= {queue_count, dropped, key_word};
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = OUT_W'(out_data_q);

	kqks_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (s_tvalid),
		.in_ready   (s_tready),
		.out_free   (out_free),
		.load_out   (load_out),
		.queue_mode (queue_mode_q),
		.flush_mode (flush_mode_q),
		.sts        (sts),
		.cmd        (cmd)
	);

	kqks_dp #(
		.QUEUE_DEPTH (QUEUE_DEPTH),
		.KEY_WORDS   (KEY_WORDS)
	) u_dp (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.in_op           (s_tuser),
		.in_code         (s_tdata[6:0]),
		.in_down         (s_tdata[7]),
		.in_now          (s_tdata[39:8]),
		.in_widx         (s_tdata[42:40]),
		.instr_threshold (instr_thr_q),
		.key_word        (key_word),
		.dropped         (dropped),
		.queue_count     (queue_count)
	);

endmodule

/* tb/tb.sv */
// Self-checking testbench for the keystroke queue key-state core.
module tb;

	localparam int QDEPTH = kqks_pkg::DEF_QUEUE_DEPTH;
	localparam int KWORDS = kqks_pkg::DEF_KEY_WORDS;

	localparam logic [1:0] OP_SPARE    = 2'd3;
	localparam logic [1:0] QMODE_TICK  = 2'd1;
	localparam logic [1:0] QMODE_INSTR = 2'd2;
	localparam logic [1:0] QMODE_SPARE = 2'd3;

	typedef enum logic [1:0] {
		IDLE_NONE,
		IDLE_SENDER,
		IDLE_RECEIVER,
		IDLE_BOTH
	} idle_t;

	typedef enum logic [1:0] {
		ROW_CHK,
		ROW_PRED,
		ROW_CFG
	} row_kind_t;

	typedef struct packed {
		logic [15:0] word;
		logic        dropped;
		logic [4:0]  count;
	} kq_out_t;

	// sel is the op of an item or the register of a write; val the instruction
	// count or the register value
	typedef struct packed {
		row_kind_t   kind;
		logic [4:0]  reps;
		logic [1:0]  sel;
		logic [6:0]  code;
		logic        down;
		logic [31:0] val;
		logic [2:0]  widx;
		logic [15:0] x_word;
		logic        x_drop;
		logic [4:0]  x_cnt;
	} dir_row_t;

	typedef struct packed {
		logic [1:0]  qm;
		logic        fm;
		logic [31:0] thr;
		idle_t       idle;
		logic [7:0]  n;
		logic        squeeze;
	} phase_t;

	logic        clk;
	logic        arst_n;
	logic        psel;
	logic        penable;
	logic        pwrite;
	logic [3:0]  paddr;
	logic [31:0] pwdata;
	logic [31:0] prdata;
	logic        pready;
	logic        s_tvalid;
	logic        s_tready;
	logic [47:0] s_tdata;
	logic [1:0]  s_tuser;
	logic        m_tvalid;
	logic        m_tready;
	logic [23:0] m_tdata;

	keystroke_queue_key_state_core dut (
		.clk      (clk),
		.arst_n   (arst_n),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.prdata   (prdata),
		.pready   (pready),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata)
	);

	// predictor state
	logic [15:0] pm_keys [KWORDS];
	logic [7:0]  pm_ring [QDEPTH];
	int unsigned pm_head;
	int unsigned pm_tail;
	int unsigned pm_fill;
	logic [31:0] pm_last;
	logic [1:0]  cfg_qmode;
	logic        cfg_fmode;
	logic [31:0] cfg_thresh;

	kq_out_t     expected_words [$];
	int unsigned err_count = 0;
	idle_t       idle_mode = IDLE_NONE;
	int unsigned hold_seq = 0;

	dir_row_t dir_tab [30] = '{
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_READ, 7'd0,   1'b0, 32'd0,        3'd0, 16'hFFFF, 1'b0,
			5'd0},
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_KEY,  7'd1,   1'b1, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_READ, 7'd0,   1'b0, 32'd0,        3'd0, 16'hBFFF, 1'b0,
			5'd0},
		// code zero is ignored
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_KEY,  7'd0,   1'b1, 32'hFFFFFFFF, 3'd7, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_KEY,  7'd127, 1'b1, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_READ, 7'd0,   1'b0, 32'd0,        3'd7, 16'hFFFE, 1'b0,
			5'd0},
		'{ROW_CHK,  5'd1,  OP_SPARE, 7'd127, 1'b1, 32'hFFFFFFFF, 3'd7, 16'h0000, 1'b0, 5'd0},
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_QUEUE_MODE, 7'd0, 1'b0, {30'd0, QMODE_TICK}, 3'd0,
			16'h0, 1'b0, 5'd0},
		// fill the queue, then overflow it
		'{ROW_PRED, 5'd16, kqks_pkg::OP_KEY,  7'h25,  1'b1, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CHK,  5'd1,  kqks_pkg::OP_KEY,  7'h26,  1'b1, 32'd0,        3'd0, 16'h0000, 1'b1,
			5'd16},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_FLUSH_MODE, 7'd0, 1'b0, {31'd0, kqks_pkg::FMODE_RUN},
			3'd0, 16'h0, 1'b0, 5'd0},
		// run stops at the repeated code
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_KEY,  7'h30,  1'b0, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_QUEUE_MODE, 7'd0, 1'b0,
			{30'd0, kqks_pkg::QMODE_DIRECT}, 3'd0, 16'h0, 1'b0, 5'd0},
		// direct-mode tick still flushes the queue, stopping at the repeated code
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_READ, 7'd0,   1'b0, 32'd0,        3'd2, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_QUEUE_MODE, 7'd0, 1'b0, {30'd0, QMODE_INSTR}, 3'd0,
			16'h0, 1'b0, 5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_INSTR_THR, 7'd0, 1'b0, 32'd10,   3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_KEY,  7'h11,  1'b1, 32'd5,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_KEY,  7'h12,  1'b1, 32'd20,       3'd0, 16'h0000, 1'b0,
			5'd0},
		// same count as the last flush, then a wrapped count
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'd20,       3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'd5,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_QUEUE_MODE, 7'd0, 1'b0, {30'd0, QMODE_SPARE}, 3'd0,
			16'h0, 1'b0, 5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_KEY,  7'h40,  1'b1, 32'd100,      3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_TICK, 7'd0,   1'b0, 32'hFFFFFFFF, 3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_CFG,  5'd1,  kqks_pkg::REG_INSTR_THR, 7'd0, 1'b0, 32'hFFFFFFFF, 3'd0, 16'h0000,
			1'b0, 5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_KEY,  7'h05,  1'b1, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0},
		'{ROW_PRED, 5'd1,  kqks_pkg::OP_READ, 7'd0,   1'b0, 32'd0,        3'd0, 16'h0000, 1'b0,
			5'd0}
	};

	phase_t phase_tab [8] = '{
		'{kqks_pkg::QMODE_DIRECT, kqks_pkg::FMODE_ONE, kqks_pkg::THRESHOLD_RESET, IDLE_NONE,
			8'd90, 1'b0},
		'{QMODE_TICK,   kqks_pkg::FMODE_ONE, kqks_pkg::THRESHOLD_RESET, IDLE_SENDER,
			8'd90, 1'b0},
		'{QMODE_TICK,   kqks_pkg::FMODE_RUN, kqks_pkg::THRESHOLD_RESET, IDLE_RECEIVER,
			8'd90, 1'b0},
		'{QMODE_INSTR,  kqks_pkg::FMODE_RUN, 32'd0,           IDLE_BOTH,     8'd90, 1'b0},
		'{QMODE_INSTR,  kqks_pkg::FMODE_ONE, kqks_pkg::THRESHOLD_RESET, IDLE_NONE,
			8'd90, 1'b1},
		'{QMODE_SPARE,  kqks_pkg::FMODE_RUN, 32'hFFFFFFFF,    IDLE_SENDER,   8'd60, 1'b0},
		'{QMODE_INSTR,  kqks_pkg::FMODE_RUN, 32'd37,          IDLE_RECEIVER, 8'd90, 1'b0},
		'{QMODE_TICK,   kqks_pkg::FMODE_RUN, kqks_pkg::THRESHOLD_RESET, IDLE_BOTH,
			8'd90, 1'b1}
	};

	function automatic void empty_ring();
		pm_head = 0;
		pm_tail = QDEPTH - 1;
		pm_fill = 0;
	endfunction

	function automatic void set_key_bit(logic [7:0] e);
		logic [15:0] b;
		b = 16'h8000 >> e[3:0];
		if (int'(e[6:4]) < KWORDS) begin
			if (e[7])
				pm_keys[e[6:4]] = pm_keys[e[6:4]] & ~b;
			else
				pm_keys[e[6:4]] = pm_keys[e[6:4]] | b;
		end
	endfunction

	function automatic void drain_ring();
		int unsigned n;
		int unsigned idx;
		bit          seen;
		n = pm_fill;
		idx = pm_head;
		if (n == 0)
			return;
		if (cfg_fmode == kqks_pkg::FMODE_ONE) begin
			set_key_bit(pm_ring[pm_head]);
			pm_fill--;
			if (pm_fill == 0)
				empty_ring();
			else
				pm_head = (pm_head + 1) % QDEPTH;
			return;
		end
		for (int unsigned i = 0; i < n; i++) begin
			seen = 1'b0;
			idx = (pm_head + i) % QDEPTH;
			for (int unsigned j = 0; j < i; j++) begin
				if (pm_ring[(pm_head + j) % QDEPTH][6:0] == pm_ring[idx][6:0]) begin
					seen = 1'b1;
					break;
				end
			end
			if (seen)
				break;
			set_key_bit(pm_ring[idx]);
			pm_fill--;
		end
		if (pm_fill == 0)
			empty_ring();
		else
			pm_head = idx;
	endfunction

	function automatic void check_instr_drain(logic [31:0] now);
		logic [63:0] el;
		if (pm_fill == 0)
			return;
		if (now > pm_last)
			el = 64'(now) - 64'(pm_last);
		else if (now < pm_last)
			el = 64'(now) + 64'(32'hFFFFFFFF - pm_last);
		else
			return;
		if (el > 64'(cfg_thresh)) begin
			drain_ring();
			pm_last = now;
		end
	endfunction

	function automatic kq_out_t predict_key_item(logic [1:0] op, logic [6:0] code, logic down,
			logic [31:0] now, logic [2:0] widx);
		kq_out_t r;
		r = '0;
		case (op)
			kqks_pkg::OP_KEY: begin
				if (code != 7'd0) begin
					if (cfg_qmode == kqks_pkg::QMODE_DIRECT) begin
						set_key_bit({down, code});
					end else begin
						if (pm_fill >= QDEPTH) begin
							r.dropped = 1'b1;
						end else begin
							pm_fill++;
							pm_tail = (pm_tail + 1) % QDEPTH;
							pm_ring[pm_tail] = {down, code};
						end
						if (cfg_qmode[1])
							check_instr_drain(now);
					end
				end
			end
			kqks_pkg::OP_TICK: begin
				if (cfg_qmode[1])
					check_instr_drain(now);
				else
					drain_ring();
			end
			kqks_pkg::OP_READ: begin
				r.word = (int'(widx) < KWORDS) ? pm_keys[widx] : 16'hFFFF;
			end
			default: ;
		endcase
		r.count = 5'(pm_fill);
		return r;
	endfunction

	function automatic bit sender_rests();
		if (idle_mode == IDLE_SENDER)
			return $urandom_range(0, 99) < 71;
		if (idle_mode == IDLE_BOTH)
			return $urandom_range(0, 99) < 6;
		return 1'b0;
	endfunction

	task automatic push_item(logic [1:0] op, logic [6:0] code, logic down, logic [31:0] instr,
			logic [2:0] widx, bit typed, kq_out_t typed_res);
		kq_out_t pred;
		@(negedge clk);
		while (sender_rests()) begin
			s_tvalid = 1'b0;
			@(negedge clk);
		end
		s_tvalid = 1'b1;
		s_tuser = op;
		s_tdata = {5'd0, widx, instr, down, code};
		do @(posedge clk); while (!s_tready);
		pred = predict_key_item(op, code, down, instr, widx);
		expected_words.push_back(typed ? typed_res : pred);
	endtask

	// drop valid and wait until every word has come back
	task automatic settle();
		@(negedge clk);
		s_tvalid = 1'b0;
		while (expected_words.size() != 0)
			@(posedge clk);
	endtask

	task automatic apb_write(logic [1:0] idx, logic [31:0] val);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = 1'b1;
		paddr = {idx, 2'b00};
		pwdata = val;
		@(negedge clk);
		penable = 1'b1;
		do @(posedge clk); while (!pready);
		case (idx)
			kqks_pkg::REG_QUEUE_MODE: cfg_qmode = val[1:0];
			kqks_pkg::REG_FLUSH_MODE: cfg_fmode = val[0];
			kqks_pkg::REG_INSTR_THR:  cfg_thresh = val;
			default: ;
		endcase
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
	endtask

	task automatic run_phase(phase_t p);
		logic [6:0]  pool [6];
		logic [1:0]  op;
		logic [6:0]  code;
		logic [31:0] instr_now;
		logic [31:0] step_max;
		int unsigned pick;
		settle();
		apb_write(kqks_pkg::REG_QUEUE_MODE, {30'd0, p.qm});
		apb_write(kqks_pkg::REG_FLUSH_MODE, {31'd0, p.fm});
		apb_write(kqks_pkg::REG_INSTR_THR, p.thr);
		idle_mode = p.idle;
		foreach (pool[i])
			pool[i] = 7'($urandom_range(1, 127));
		instr_now = ($urandom_range(0, 1) != 0) ? $urandom : 32'hFFFFF000;
		step_max = (p.thr > 32'd5000) ? 32'd3000 : 2 * p.thr + 32'd8;
		if (p.squeeze)
			hold_seq++;
		for (int k = 0; k < p.n; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 58)
				op = kqks_pkg::OP_KEY;
			else if (pick < 78)
				op = kqks_pkg::OP_TICK;
			else if (pick < 96)
				op = kqks_pkg::OP_READ;
			else
				op = OP_SPARE;
			pick = $urandom_range(0, 99);
			if (pick < 4)
				code = 7'd0;
			else if (pick < 60)
				code = pool[$urandom_range(0, 5)];
			else
				code = 7'($urandom_range(1, 127));
			if ($urandom_range(0, 99) < 6)
				instr_now = $urandom;
			else
				instr_now = instr_now + $urandom_range(0, step_max);
			push_item(op, code, 1'($urandom_range(0, 1)), instr_now, 3'($urandom_range(0, 7)),
				1'b0, '0);
		end
	endtask

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	initial begin
		#5_000_000;
		$display("keystroke_queue_key_state_core: mismatch");
		$finish;
	end

	// receiver: random stalls in the receiver-idle modes, plus a long hold-off whenever one is requested
	initial begin
		int unsigned hold_left;
		int unsigned hold_seen;
		hold_left = 0;
		hold_seen = 0;
		m_tready = 1'b0;
		forever begin
			@(negedge clk);
			if (hold_left != 0) begin
				hold_left--;
				m_tready = 1'b0;
			end else if (hold_seen != hold_seq) begin
				hold_seen = hold_seq;
				hold_left = 299;
				m_tready = 1'b0;
			end else begin
				case (idle_mode)
					IDLE_RECEIVER: m_tready = $urandom_range(0, 99) >= 71;
					IDLE_BOTH:     m_tready = $urandom_range(0, 99) >= 6;
					default:       m_tready = 1'b1;
				endcase
			end
		end
	end

	initial begin
		kq_out_t got;
		kq_out_t want;
		forever begin
			@(posedge clk);
			if (arst_n && m_tvalid && m_tready) begin
				got = {m_tdata[15:0], m_tdata[16], m_tdata[21:17]};
				if (expected_words.size() == 0) begin
					err_count++;
					$display("%0t: unexpected word: word %h dropped %0d count %0d",
						$time, got.word, got.dropped, got.count);
				end else begin
					want = expected_words.pop_front();
					if (got !== want) begin
						err_count++;
						$display("%0t: expected word %h dropped %0d count %0d, got word %h dropped %0d count %0d",
							$time, want.word, want.dropped, want.count,
							got.word, got.dropped, got.count);
					end
				end
			end
		end
	end

	initial begin
		dir_row_t row;
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		s_tuser = '0;
		foreach (pm_keys[i])
			pm_keys[i] = 16'hFFFF;
		foreach (pm_ring[i])
			pm_ring[i] = 8'h00;
		empty_ring();
		pm_last = '0;
		cfg_qmode = kqks_pkg::QMODE_DIRECT;
		cfg_fmode = kqks_pkg::FMODE_ONE;
		cfg_thresh = kqks_pkg::THRESHOLD_RESET;
		repeat (12) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_tab[r]) begin
			row = dir_tab[r];
			if (row.kind == ROW_CFG) begin
				settle();
				apb_write(row.sel, row.val);
			end else begin
				for (int k = 0; k < row.reps; k++)
					push_item(row.sel, row.code, row.down, row.val, row.widx,
						row.kind == ROW_CHK, {row.x_word, row.x_drop, row.x_cnt});
			end
		end

		foreach (phase_tab[p])
			run_phase(phase_tab[p]);

		settle();
		repeat (40) @(posedge clk);
		if (err_count == 0 && expected_words.size() == 0)
			$display("keystroke_queue_key_state_core: match");
		else
			$display("keystroke_queue_key_state_core: mismatch");
		$finish;
	end

endmodule
